[rtl/core/signed_int_to_decimal_ascii_top_assert.svh]
// Assertion macros for the signed integer to decimal text block.
// Used by the port checker; expects clk and rst_n in the scope of use.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_TOP_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_TOP_ASSERT_SVH

// Same-cycle implication, masked while reset is asserted.
`define SITDA_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define SITDA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/sitda_pkg.sv]
// Shared types, constants and elaboration-time tables for the decimal text block.
// No dependencies; every other source file but the assertion header imports this package.
`timescale 1ns / 1ps

package sitda_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int MAX_DIGITS  = 10;
    localparam int MAG_W       = VALUE_WIDTH;
    localparam int RADIX       = 10;
    localparam int CHAR_W      = 7;
    localparam int DIGIT_W     = 4;
    localparam int CALC_W      = 68;   // holds 9 * 10^19 without overflow

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'd45;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Decimal digits in the largest magnitude, 2^(VALUE_WIDTH-1).
    function automatic int digits_needed();
        logic [CALC_W-1:0] big;
        logic [CALC_W-1:0] pw;
        int                n;
        big = CALC_W'(1) << (VALUE_WIDTH - 1);
        pw  = CALC_W'(RADIX);
        n   = 1;
        for (int i = 0; i < 20; i++)
        begin
            if (pw <= big)
            begin
                n++;
                pw = pw * CALC_W'(RADIX);
            end
        end
        return n;
    endfunction

    localparam int DIG_NEED = digits_needed();
    localparam int POS_N    = (MAX_DIGITS > DIG_NEED) ? MAX_DIGITS : DIG_NEED;
    localparam int POS_W    = $clog2(POS_N);

    typedef logic [MAG_W-1:0] mag_t;

    typedef struct packed {
        logic neg;
        mag_t mag;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // Multiples k * 10^p for k = 1..9, saturated to all ones above the magnitude range.
    typedef logic [POS_N-1:0][RADIX-2:0][MAG_W:0] steps_t;

    function automatic steps_t build_steps();
        logic [CALC_W-1:0] pw;
        logic [CALC_W-1:0] acc;
        steps_t            t;
        pw = CALC_W'(1);
        for (int p = 0; p < POS_N; p++)
        begin
            for (int k = 0; k < RADIX - 1; k++)
            begin
                acc = pw * CALC_W'(k + 1);
                if ((acc >> (MAG_W + 1)) != '0)
                    t[p][k] = '1;
                else
                    t[p][k] = acc[MAG_W:0];
            end
            pw = pw * CALC_W'(RADIX);
        end
        return t;
    endfunction

    localparam steps_t STEPS = build_steps();

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SIGN,
        BK_DIGIT
    } back_state_t;

endpackage

[rtl/core/sitda_queue.sv]
// Short request queue between the front and back parts of the decimal text block.
// Depends on sitda_pkg.
`timescale 1ns / 1ps

module sitda_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  sitda_pkg::item_t wr_item,
    input  logic             pop,
    output sitda_pkg::item_t rd_item,
    output sitda_pkg::q_stat_t stat
);
    import sitda_pkg::*;

    item_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold payload; no reset needed.
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_item;
    end

    assign rd_item    = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

[rtl/core/sitda_front.sv]
// Front part: accepts a request, splits it into sign and unsigned magnitude.
// Depends on sitda_pkg.
`timescale 1ns / 1ps

module sitda_front (
    input  logic                                     start,
    input  logic signed [sitda_pkg::VALUE_WIDTH-1:0] value,
    input  sitda_pkg::q_stat_t                       stat,
    output logic                                     busy,
    output logic                                     push,
    output sitda_pkg::item_t                         wr_item
);
    import sitda_pkg::*;

    logic [VALUE_WIDTH-1:0] raw;
    logic                   neg;

    assign raw  = value;
    assign neg  = raw[VALUE_WIDTH-1];
    assign busy = stat.full;
    assign push = start && !stat.full;

    // Negate in unsigned arithmetic so the most negative value maps to 2^(W-1).
    assign wr_item.neg = neg;
    assign wr_item.mag = neg ? mag_t'(~raw + 1'b1) : mag_t'(raw);

endmodule

[rtl/core/sitda_back.sv]
// Back part: turns one queued magnitude into ASCII characters, most significant first.
// Depends on sitda_pkg (digit step table, state type).
`timescale 1ns / 1ps

module sitda_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  sitda_pkg::q_stat_t              stat,
    input  sitda_pkg::item_t                rd_item,
    output logic                            pop,
    output logic                            char_valid,
    output logic [sitda_pkg::CHAR_W-1:0]    char_code,
    output logic                            last
);
    import sitda_pkg::*;

    back_state_t        state_reg;
    back_state_t        state_next;
    mag_t               mag_reg;
    mag_t               mag_next;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic               started_reg;
    logic               started_next;
    logic               valid_reg;
    logic               valid_next;
    logic [CHAR_W-1:0]  code_reg;
    logic [CHAR_W-1:0]  code_next;
    logic               last_reg;
    logic               last_next;

    logic [MAG_W+1:0]   diff [RADIX-1];
    logic [RADIX-2:0]   ge;
    logic [DIGIT_W-1:0] digit;
    mag_t               mag_rem;

    // One decimal digit per cycle: compare against all nine multiples of 10^pos.
    always_comb
    begin
        for (int k = 0; k < RADIX - 1; k++)
        begin
            diff[k] = {2'b00, mag_reg} - {1'b0, STEPS[pos_reg][k]};
            ge[k]   = ~diff[k][MAG_W+1];
        end
        digit   = '0;
        mag_rem = mag_reg;
        for (int k = 0; k < RADIX - 1; k++)
        begin
            if (ge[k])
            begin
                digit   = DIGIT_W'(k + 1);
                mag_rem = diff[k][MAG_W-1:0];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!stat.empty)
                    state_next = rd_item.neg ? BK_SIGN : BK_DIGIT;
            end
            BK_SIGN:
                state_next = BK_DIGIT;
            BK_DIGIT:
            begin
                if (pos_reg == '0)
                    state_next = BK_IDLE;
            end
            default:
                state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        pop          = 1'b0;
        mag_next     = mag_reg;
        pos_next     = pos_reg;
        started_next = started_reg;
        valid_next   = 1'b0;
        code_next    = code_reg;
        last_next    = last_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!stat.empty)
                begin
                    pop          = 1'b1;
                    mag_next     = rd_item.mag;
                    pos_next     = POS_W'(POS_N - 1);
                    started_next = 1'b0;
                end
            end
            BK_SIGN:
            begin
                valid_next = 1'b1;
                code_next  = ASCII_MINUS;
                last_next  = 1'b0;
            end
            BK_DIGIT:
            begin
                mag_next     = mag_rem;
                pos_next     = pos_reg - 1'b1;
                started_next = started_reg || (digit != '0);
                // Drop positions above the kept digit count and leading zeros.
                if (int'(pos_reg) < MAX_DIGITS
                    && (started_reg || digit != '0 || pos_reg == '0))
                begin
                    valid_next = 1'b1;
                    code_next  = ASCII_ZERO + CHAR_W'(digit);
                    last_next  = (pos_reg == '0);
                end
            end
            default:
            begin
                valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg     <= mag_next;
        pos_reg     <= pos_next;
        started_reg <= started_next;
        code_reg    <= code_next;
        last_reg    <= last_next;
    end

    assign char_valid = valid_reg;
    assign char_code  = code_reg;
    assign last       = last_reg;

endmodule

[rtl/core/signed_int_to_decimal_ascii_top.sv]
// Top level of the signed integer to decimal ASCII text block.
// Depends on sitda_pkg, sitda_front, sitda_queue and sitda_back.
`timescale 1ns / 1ps

// Signed integer to decimal ASCII text.
// Raise start with a value while busy is low and the request is taken at that
// clock edge. The block answers with the decimal text of the value, one ASCII
// character at a time on char_code, each marked by a single-cycle char_valid
// strobe, most significant digit first: a leading '-' for a negative value,
// no leading zeros, a single '0' for zero, and last set on the final
// character. The most negative value prints in full ("-2147483648" at 32
// bits). The receiver cannot stall: it must take every character in the
// cycle it is shown. Requests wait in a two-entry queue, so busy rises only
// when two requests are waiting behind the one being printed.
// Steps: the converter loads a request in its idle state, passes through its
// sign state for the '-' of a negative value, then works one decimal position
// per cycle (10 positions at 32 bits) in its digit state. The cost per
// position is set by the digit step: nine parallel compares against the
// multiples of a power of ten and a select of the remainder. Characters of
// one value come out back to back once the first nonzero digit is reached;
// the '-' is registered out of the sign state and a first digit out of the
// digit state, so a positive value with few digits shows its first character later.

module signed_int_to_decimal_ascii_top (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     start,
    output logic                                     busy,
    input  logic signed [sitda_pkg::VALUE_WIDTH-1:0] value,
    output logic                                     char_valid,
    output logic [sitda_pkg::CHAR_W-1:0]             char_code,
    output logic                                     last
);
    import sitda_pkg::*;

    // Request path between front, queue and converter.
    logic    push;
    logic    pop;
    item_t   wr_item;
    item_t   rd_item;
    q_stat_t stat;

    // Classify the request: sign flag and unsigned magnitude.
    sitda_front u_front (
        .start   (start),
        .value   (value),
        .stat    (stat),
        .busy    (busy),
        .push    (push),
        .wr_item (wr_item)
    );

    // Hold classified requests so intake and conversion stall independently.
    sitda_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_item (wr_item),
        .pop     (pop),
        .rd_item (rd_item),
        .stat    (stat)
    );

    // Convert one magnitude at a time and drive the character strobe.
    sitda_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .stat       (stat),
        .rd_item    (rd_item),
        .pop        (pop),
        .char_valid (char_valid),
        .char_code  (char_code),
        .last       (last)
    );

endmodule

[rtl/core/sitda_checker.sv]
// Port-level checker for the decimal text block, bound to the top level.
// Depends on sitda_pkg and signed_int_to_decimal_ascii_top_assert.svh.
`timescale 1ns / 1ps
`include "signed_int_to_decimal_ascii_top_assert.svh"

module sitda_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         char_valid,
    input logic [sitda_pkg::CHAR_W-1:0] char_code,
    input logic                         last
);
    import sitda_pkg::*;

    logic is_minus;
    logic is_digit;

    assign is_minus = (char_code == ASCII_MINUS);
    assign is_digit = (char_code >= ASCII_ZERO) && (char_code <= ASCII_ZERO + 7'd9);

    // Only '-' or a digit ever leaves the block.
    `SITDA_ASSERT_IMPLY(a_char_set, char_valid, is_minus || is_digit, "character outside set")

    // A sign is never the final character.
    `SITDA_ASSERT_IMPLY(a_sign_not_last, char_valid && is_minus, !last, "sign flagged as last")

    // Once the digits start, they run back to back and a sign never reappears.
    `SITDA_ASSERT_NEXT(a_run_unbroken, char_valid && is_digit && !last, char_valid && is_digit, "gap or sign inside digits")

    // The converter passes through its load state before the next value's text.
    `SITDA_ASSERT_NEXT(a_gap_after_last, char_valid && last, !char_valid, "character directly after last")

endmodule

bind signed_int_to_decimal_ascii_top sitda_checker u_sitda_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .char_valid (char_valid),
    .char_code  (char_code),
    .last       (last)
);

[tb/decimal_text_checker.sv]
// Checker for the signed integer to decimal text block: predicts and compares characters.
// Depends on sitda_pkg for the value and character widths and the digit limit.
`timescale 1ns / 1ps

module decimal_text_checker (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     start,
    input  logic                                     busy,
    input  logic signed [sitda_pkg::VALUE_WIDTH-1:0] value,
    input  logic                                     char_valid,
    input  logic [sitda_pkg::CHAR_W-1:0]             char_code,
    input  logic                                     last,
    output int                                       failures,
    output int                                       pending,
    output int                                       chars_seen
);

    import sitda_pkg::*;

    localparam logic [CHAR_W-1:0] CODE_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0] CODE_MINUS = 7'd45;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } text_char_t;

    text_char_t expected_chars[$];
    int         mismatch_count = 0;
    int         checked_count  = 0;

    // Push the decimal text of one value, most significant digit first.
    function automatic void predict_text(input logic [VALUE_WIDTH-1:0] raw);
        logic                   negative;
        logic [VALUE_WIDTH-1:0] mag;
        logic [3:0]             digs[0:19];
        int                     count;
        logic                   more;
        text_char_t             c;
        negative = raw[VALUE_WIDTH-1];
        mag      = negative ? (~raw + 1'b1) : raw;
        count    = 0;
        more     = 1'b1;
        while (more)
        begin
            digs[count] = 4'(mag % VALUE_WIDTH'(10));
            mag         = mag / VALUE_WIDTH'(10);
            count++;
            more = (mag != '0) && (count < MAX_DIGITS);
        end
        if (negative)
        begin
            c.code = CODE_MINUS;
            c.last = 1'b0;
            expected_chars.push_back(c);
        end
        for (int i = count - 1; i >= 0; i--)
        begin
            c.code = CODE_ZERO + CHAR_W'(digs[i]);
            c.last = (i == 0);
            expected_chars.push_back(c);
        end
    endfunction

    always @(posedge clk)
    begin
        text_char_t want;
        if (rst_n)
        begin
            if (char_valid)
            begin
                checked_count++;
                if (expected_chars.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected character: expected none, got code %0d last %0b",
                             $time, char_code, last);
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (char_code !== want.code)
                    begin
                        mismatch_count++;
                        $display("%0t: char_code mismatch: expected %0d, got %0d",
                                 $time, want.code, char_code);
                    end
                    if (last !== want.last)
                    begin
                        mismatch_count++;
                        $display("%0t: last mismatch: expected %0b, got %0b",
                                 $time, want.last, last);
                    end
                end
            end
            if (start && !busy)
                predict_text(value);
        end
        failures   <= mismatch_count;
        pending    <= expected_chars.size();
        chars_seen <= checked_count;
    end

endmodule

[tb/testbench.sv]
// Top of the testbench for the signed integer to decimal text block: stimulus and verdict.
// Depends on sitda_pkg, signed_int_to_decimal_ascii_top and decimal_text_checker.
`timescale 1ns / 1ps

module testbench;

    import sitda_pkg::*;

    localparam int RANDOM_REQUESTS = 110;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int SETTLE_CYCLES   = 40;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          char_valid;
    logic [CHAR_W-1:0]             char_code;
    logic                          last;

    int failures;
    int pending;
    int chars_seen;
    int cycles       = 0;
    int sent_count   = 0;
    int neg_count    = 0;
    int zero_count   = 0;

    // Corner values: zero, one digit, several digit-count boundaries, both
    // extremes including the most negative value, alternating bit patterns.
    logic [VALUE_WIDTH-1:0] corner_values[0:20] = '{
        32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, -32'd9, 32'd10, -32'd10,
        32'd99, 32'd100, -32'd101, 32'd999999999, 32'd1000000000,
        -32'd1000000000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
        32'd1234567890, -32'd1234567890, 32'h5555_5555, 32'hAAAA_AAAA, 32'd7
    };

    int unsigned decade[0:9] = '{
        1, 10, 100, 1000, 10000, 100000, 1000000, 10000000, 100000000, 1000000000
    };

    signed_int_to_decimal_ascii_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .value      (value),
        .char_valid (char_valid),
        .char_code  (char_code),
        .last       (last)
    );

    decimal_text_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .value      (value),
        .char_valid (char_valid),
        .char_code  (char_code),
        .last       (last),
        .failures   (failures),
        .pending    (pending),
        .chars_seen (chars_seen)
    );

    always #2 clk = ~clk;

    // Watchdog: abort a hung run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d characters still expected", cycles, pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Present one request and hold it until the block takes it. Leave start
    // high afterwards; the caller drops it only when a gap follows, so start
    // never gets two assignments in one time step.
    task automatic send_value(input logic [VALUE_WIDTH-1:0] v);
        start <= 1'b1;
        value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent_count++;
        if (v[VALUE_WIDTH-1])
            neg_count++;
        if (v == '0)
            zero_count++;
    endtask

    // Idle the sender for a drawn number of cycles.
    task automatic sender_gap(input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            value <= $urandom;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop start and hold off until every expected character has come out.
    // The wait before the first check of pending lets the checker count the request just taken.
    task automatic drain_text();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [VALUE_WIDTH-1:0] v;
        int                     kind;
        int                     n;
        int                     gap;
        logic                   no_gap;

        rst_n <= 1'b0;
        start <= 1'b0;
        value <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners, with the first few back to back.
        for (int i = 0; i < 21; i++)
        begin
            send_value(corner_values[i]);
            sender_gap((i < 6) ? 0 : $urandom_range(0, 16));
        end

        // Hold off once until the block has flushed all text.
        drain_text();

        no_gap = 1'b0;
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            // Switch pacing every 20 requests; force one back-to-back stretch.
            if (i % 20 == 0)
                no_gap = (i == 40) || ($urandom_range(0, 2) == 0);

            kind = $urandom_range(0, 9);
            if (kind <= 2)
            begin
                // Full-range pattern: every bit drawn at random.
                v = $urandom;
            end
            else if (kind <= 6)
            begin
                // At most a drawn number of digits, random sign.
                n = $urandom_range(1, 9);
                v = $urandom_range(0, decade[n] - 1);
                if ($urandom_range(0, 1))
                    v = -v;
            end
            else if (kind == 7)
            begin
                // Near either extreme.
                if ($urandom_range(0, 1))
                    v = 32'h8000_0000 + $urandom_range(0, 20);
                else
                    v = 32'h7FFF_FFFF - $urandom_range(0, 20);
            end
            else
            begin
                // Power of ten and its neighbors, random sign.
                n = $urandom_range(0, 9);
                v = decade[n] + $urandom_range(0, 2) - 1;
                if ($urandom_range(0, 1))
                    v = -v;
            end

            send_value(v);

            if (i == 70)
                drain_text();
            else
            begin
                gap = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
                sender_gap(gap);
            end
        end

        drain_text();
        // Catch any stray characters after the last expected one.
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Converted %0d values (%0d negative, %0d zero); %0d characters compared",
                 sent_count, neg_count, zero_count, chars_seen);
        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
